### hw/rtl/alwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alwc_pkg
// shared types and constants for the array list with cursor
// ----------------------------------------------------------------------------
package alwc_pkg;

    localparam int DATA_W     = 32;
    localparam int LEN_W      = 11;
    localparam int OP_W       = 4;
    localparam int STAT_W     = 2;
    localparam int ITEM_DEPTH = 1024;

    localparam logic [LEN_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 4'd0,
        OP_INSERT = 4'd1,
        OP_APPEND = 4'd2,
        OP_REMOVE = 4'd3,
        OP_START  = 4'd4,
        OP_END    = 4'd5,
        OP_PREV   = 4'd6,
        OP_NEXT   = 4'd7,
        OP_MOVE   = 4'd8,
        OP_READ   = 4'd9
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NO_CUR  = 2'd2,
        STAT_BAD_POS = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_FINAL,
        S_SHIFT_DN,
        S_RD_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        stat_t               status;
        logic [DATA_W-1:0]   read_value;
        logic [LEN_W-1:0]    list_length;
        logic [LEN_W-1:0]    cursor_position;
        logic                is_empty;
        logic                at_end;
    } alwc_res_t;

endpackage

### hw/rtl/array_list_with_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_with_cursor
// ordered list of signed 32-bit items in a ram, with length and cursor
// ----------------------------------------------------------------------------
// One item is worked at a time. Clear, append, cursor moves and every error
// case go from idle straight to the done state; read passes through a wait
// state for the registered ram read; remove runs a shift-down loop from the
// cursor to the tail; insert runs a shift-up loop from the tail down to the
// cursor and then a final write, or writes at once with the cursor at the end.
// The shifts of insert and remove move one entry per cycle through the single
// write port of the item ram. The next item is taken as soon as the previous
// result has moved to the output register, even if that result is still
// stalled. The capacity register may be written at any idle time; effective
// capacity is the lesser of capacity and DEPTH. The item ram needs no
// clearing after reset: only entries below the length are ever read.
// ----------------------------------------------------------------------------
module array_list_with_cursor
    import alwc_pkg::*;
#(
    parameter int DEPTH = ITEM_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // capacity register
    input  logic                     cfg_we,
    input  logic [LEN_W-1:0]         cfg_wdata,
    // operation items
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [LEN_W-1:0]         position,
    // result items
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [LEN_W-1:0]         list_length,
    output logic [LEN_W-1:0]         cursor_position,
    output logic                     is_empty,
    output logic                     at_end
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [LEN_W-1:0]  capacity_reg, capacity_next;
    logic              out_valid_reg, out_valid_next;
    alwc_res_t         res_out_reg;
    alwc_res_t         res;
    logic              res_valid;
    logic              res_take;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    // capacity register, write only
    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    // output slot is free when empty or being emptied this cycle
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only when the slot takes a new item
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            res_out_reg <= res;
        end
    end

    alwc_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (capacity_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .item_value (item_value),
        .position   (position),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // item store
    alwc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_item_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign status          = res_out_reg.status;
    assign read_value      = res_out_reg.read_value;
    assign list_length     = res_out_reg.list_length;
    assign cursor_position = res_out_reg.cursor_position;
    assign is_empty        = res_out_reg.is_empty;
    assign at_end          = res_out_reg.at_end;

`ifndef SYNTHESIS
    a_take_fills_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> out_valid_reg)
        else $error("finished result did not reach the output slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !res_take)
        else $error("stalled output overwritten");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (is_empty == (list_length == '0)) &&
        (at_end == (cursor_position == list_length)))
        else $error("empty or at-end flag disagrees with length and cursor");
`endif

endmodule

### hw/rtl/alwc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alwc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module alwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/alwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alwc_ctrl
// operation sequencer: count, cursor and the shift loops over the item ram
// ----------------------------------------------------------------------------
module alwc_ctrl
    import alwc_pkg::*;
#(
    parameter int DEPTH = ITEM_DEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LEN_W-1:0]  capacity,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   operation,
    input  logic [DATA_W-1:0] item_value,
    input  logic [LEN_W-1:0]  position,
    output logic              res_valid,
    input  logic              res_take,
    output alwc_res_t         res,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic [AW-1:0]     mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    state_t            state_reg,  state_next;
    logic [LEN_W-1:0]  count_reg,  count_next;
    logic [LEN_W-1:0]  cursor_reg, cursor_next;
    logic [LEN_W-1:0]  idx_reg,    idx_next;
    stat_t             status_reg, status_next;
    logic [DATA_W-1:0] rd_reg,     rd_next;
    logic [DATA_W-1:0] val_reg,    val_next;
    logic              full;
    logic              no_cur;

    function automatic logic [AW-1:0] to_addr(input logic [LEN_W-1:0] v);
        logic [LEN_W+AW-1:0] wide;
        wide = {{AW{1'b0}}, v};
        return wide[AW-1:0];
    endfunction

    // effective capacity is the lesser of the register and the ram depth
    assign full   = (count_reg >= capacity) || ({21'd0, count_reg} >= 32'(DEPTH));
    assign no_cur = (cursor_reg >= count_reg);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        val_next    = val_reg;
        mem_we      = 1'b0;
        mem_waddr   = to_addr(idx_reg);
        mem_wdata   = mem_rdata;
        mem_raddr   = to_addr(cursor_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next    = item_value;
                    status_next = STAT_OK;
                    rd_next     = '0;
                    state_next  = S_DONE;
                    unique case (op_t'(operation))
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else if (cursor_reg == count_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = to_addr(cursor_reg);
                                mem_wdata  = item_value;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                // start moving items up from the tail
                                idx_next   = count_reg - 1'b1;
                                mem_raddr  = to_addr(count_reg - 1'b1);
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = to_addr(count_reg);
                                mem_wdata  = item_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (no_cur)
                            begin
                                status_next = STAT_NO_CUR;
                            end
                            else
                            begin
                                idx_next   = cursor_reg;
                                mem_raddr  = to_addr(cursor_reg);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_START:
                        begin
                            cursor_next = '0;
                        end
                        OP_END:
                        begin
                            cursor_next = count_reg;
                        end
                        OP_PREV:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - 1'b1;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (cursor_reg < count_reg)
                            begin
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        OP_MOVE:
                        begin
                            if (position > count_reg)
                            begin
                                status_next = STAT_BAD_POS;
                            end
                            else
                            begin
                                cursor_next = position;
                            end
                        end
                        OP_READ:
                        begin
                            if (no_cur)
                            begin
                                status_next = STAT_NO_CUR;
                            end
                            else
                            begin
                                mem_raddr  = to_addr(cursor_reg);
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // data of entry idx arrives, lands one place higher
                mem_we    = 1'b1;
                mem_waddr = to_addr(idx_reg + 1'b1);
                mem_wdata = mem_rdata;
                if (idx_reg == cursor_reg)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    idx_next  = idx_reg - 1'b1;
                    mem_raddr = to_addr(idx_reg - 1'b1);
                end
            end
            S_FINAL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = to_addr(cursor_reg);
                mem_wdata  = val_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_SHIFT_DN:
            begin
                // first beat returns the removed item, later beats move down
                if (idx_reg == cursor_reg)
                begin
                    rd_next = mem_rdata;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = to_addr(idx_reg - 1'b1);
                    mem_wdata = mem_rdata;
                end
                if ((idx_reg + 1'b1) < count_reg)
                begin
                    idx_next  = idx_reg + 1'b1;
                    mem_raddr = to_addr(idx_reg + 1'b1);
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
            begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        val_reg    <= val_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res.status          = status_reg;
        res.read_value      = rd_reg;
        res.list_length     = count_reg;
        res.cursor_position = cursor_reg;
        res.is_empty        = (count_reg == '0);
        res.at_end          = (cursor_reg == count_reg);
    end

`ifndef SYNTHESIS
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond item count");

    a_count_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        {21'd0, count_reg} <= 32'(DEPTH))
        else $error("item count beyond ram depth");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_UP || state_reg == S_SHIFT_DN) |->
        (idx_reg >= cursor_reg && idx_reg < count_reg))
        else $error("shift index outside cursor to tail");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !res_take) |=>
        (state_reg == S_DONE && $stable(count_reg) && $stable(cursor_reg)))
        else $error("finished result changed before it was taken");
`endif

endmodule
